[sv/bitmap_first_free_allocator_defines.svh]
// Assertion macros for the verification files of the allocator.
`ifndef BITMAP_FIRST_FREE_ALLOCATOR_DEFINES_SVH
`define BITMAP_FIRST_FREE_ALLOCATOR_DEFINES_SVH

// Check a property outside of reset.
`define BFFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check a property at every edge, reset included.
`define BFFA_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

[sv/bffa_pkg.sv]
`timescale 1ns / 1ps

package bffa_pkg;

  // Field and register widths
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned POS_W   = 14;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned LIMIT_W = 15;
  // Running base position: a limit value plus one word step
  localparam int unsigned BASE_W  = LIMIT_W + 1;

  localparam logic [LIMIT_W-1:0] BLOCK_LIMIT_RST = 15'd16384;

  // Request modes
  localparam logic [MODE_W-1:0] MODE_FIND   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TOGGLE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ALLOC  = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NONE_FREE = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE     = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [POS_W-1:0]  bit_index;
  } alloc_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  position;
  } alloc_rsp_t;

  typedef enum logic [2:0] {
    SEQ_CLEAR,
    SEQ_IDLE,
    SEQ_SEEK,
    SEQ_TGL,
    SEQ_SCAN,
    SEQ_DONE
  } seq_state_e;

endpackage

[sv/bitmap_first_free_allocator.sv]
`timescale 1ns / 1ps

// Bitmap free-block allocator: one usage bit per block in a word-wide RAM of
// ceil(MAP_BITS / WORD_BITS) words, with one request in work at a time.
// After reset the block runs a clearing pass of one word per cycle with
// req_ready_o low; cfg writes are taken throughout. A find or allocate
// request scans the map from word 0 at one word per cycle through a single
// clear-bit finder, visiting up to ceil(limit / WORD_BITS) words. A toggle
// steps the shared word counter one word per cycle up to the word holding
// bit_index, then reads and writes it back. The result register frees the
// core, so the next request can be taken while a result waits.
module bitmap_first_free_allocator import bffa_pkg::*; #(
  parameter int unsigned MAP_BITS = 16384,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  input  alloc_req_t         req_i,
  output logic               rsp_valid_o,
  input  logic               rsp_ready_i,
  output alloc_rsp_t         rsp_o,
  input  logic               cfg_we_i,
  input  logic [LIMIT_W-1:0] cfg_wdata_i
);

  localparam int unsigned MapWords = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AddrW = (MapWords > 1) ? $clog2(MapWords) : 1;

  logic                 ram_we;
  logic [AddrW-1:0]     ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [AddrW-1:0]     ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  // Sequencer with the shared word scan
  bffa_seq #(
    .MAP_BITS  (MAP_BITS),
    .WORD_BITS (WORD_BITS),
    .MAP_WORDS (MapWords),
    .ADDR_W    (AddrW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_ready_i (rsp_ready_i),
    .rsp_o       (rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  // Usage map storage
  bffa_word_ram #(
    .DEPTH  (MapWords),
    .WIDTH  (WORD_BITS),
    .ADDR_W (AddrW)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

[sv/bffa_word_ram.sv]
`timescale 1ns / 1ps

module bffa_word_ram #(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned WIDTH = 32,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

[sv/bffa_free_scan.sv]
`timescale 1ns / 1ps

module bffa_free_scan import bffa_pkg::*; #(
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned OFF_W = $clog2(WORD_BITS)
) (
  input  logic [WORD_BITS-1:0] word_i,
  input  logic [BASE_W-1:0]    base_i,
  input  logic [LIMIT_W-1:0]   limit_i,
  output logic                 found_o,
  output logic [OFF_W-1:0]     offset_o,
  output logic [WORD_BITS-1:0] onehot_o
);

  logic [BASE_W-1:0]    rem;
  logic [WORD_BITS-1:0] avail;

  // Positions left below the limit, counted from the word base
  assign rem = BASE_W'(limit_i) - base_i;

  // Mark clear bits that still lie below the limit
  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      avail[i] = ~word_i[i] && (BASE_W'(i) < rem);
    end
  end

  // Isolate the lowest free bit
  assign onehot_o = avail & ((~avail) + WORD_BITS'(1));
  assign found_o  = |avail;

  // Encode the one-hot bit into an offset
  always_comb begin
    offset_o = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (onehot_o[i]) begin
        offset_o = offset_o | OFF_W'(i);
      end
    end
  end

endmodule

[sv/bffa_seq.sv]
`timescale 1ns / 1ps

module bffa_seq import bffa_pkg::*; #(
  parameter int unsigned MAP_BITS = 16384,
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS,
  parameter int unsigned ADDR_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  output logic                 req_ready_o,
  input  alloc_req_t           req_i,
  output logic                 rsp_valid_o,
  input  logic                 rsp_ready_i,
  output alloc_rsp_t           rsp_o,
  input  logic                 cfg_we_i,
  input  logic [LIMIT_W-1:0]   cfg_wdata_i,
  output logic                 ram_we_o,
  output logic [ADDR_W-1:0]    ram_waddr_o,
  output logic [WORD_BITS-1:0] ram_wdata_o,
  output logic [ADDR_W-1:0]    ram_raddr_o,
  input  logic [WORD_BITS-1:0] ram_rdata_i
);

  localparam int unsigned OffW = $clog2(WORD_BITS);
  localparam logic [31:0] MapBitsV = 32'(MAP_BITS);
  localparam logic [ADDR_W-1:0] LastWord = ADDR_W'(MAP_WORDS - 1);
  localparam logic [BASE_W-1:0] WordStep = BASE_W'(WORD_BITS);

  seq_state_e state_q, state_d;
  logic [ADDR_W-1:0]    w_q, w_d;
  logic [BASE_W-1:0]    base_q, base_d;
  logic [LIMIT_W-1:0]   limit_q;
  logic [MODE_W-1:0]    mode_q;
  logic [POS_W-1:0]     idx_q;
  alloc_rsp_t           res_q, res_d;
  alloc_rsp_t           rsp_q;
  logic                 rsp_valid_q;

  logic [LIMIT_W-1:0]   eff_lim;
  logic [BASE_W-1:0]    base_next;
  logic                 seek_hit;
  logic                 scan_last;
  logic [OffW-1:0]      tgl_off;
  logic [WORD_BITS-1:0] tgl_mask;
  logic                 scan_found;
  logic [OffW-1:0]      scan_off;
  logic [WORD_BITS-1:0] scan_onehot;
  logic [BASE_W-1:0]    scan_pos;
  logic                 rsp_free;
  logic                 req_xfer;

  // Clamp the limit to the map size
  assign eff_lim = (32'(limit_q) > MapBitsV) ? MapBitsV[LIMIT_W-1:0] : limit_q;

  // Shared word stepper: base position and compares against it
  assign base_next = base_q + WordStep;
  assign seek_hit  = BASE_W'(idx_q) < base_next;
  assign scan_last = base_next >= BASE_W'(eff_lim);
  assign tgl_off   = OffW'(BASE_W'(idx_q) - base_q);
  assign tgl_mask  = WORD_BITS'(1) << tgl_off;
  assign scan_pos  = base_q + BASE_W'(scan_off);

  assign rsp_free = !rsp_valid_q || rsp_ready_i;
  assign req_xfer = req_valid_i && req_ready_o;

  bffa_free_scan #(
    .WORD_BITS (WORD_BITS)
  ) u_scan (
    .word_i   (ram_rdata_i),
    .base_i   (base_q),
    .limit_i  (eff_lim),
    .found_o  (scan_found),
    .offset_o (scan_off),
    .onehot_o (scan_onehot)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SEQ_CLEAR: begin
        if (w_q == LastWord) state_d = SEQ_IDLE;
      end
      SEQ_IDLE: begin
        if (req_valid_i) begin
          if (req_i.mode == MODE_TOGGLE) begin
            state_d = (LIMIT_W'(req_i.bit_index) >= eff_lim) ? SEQ_DONE : SEQ_SEEK;
          end else begin
            state_d = (eff_lim == '0) ? SEQ_DONE : SEQ_SCAN;
          end
        end
      end
      SEQ_SEEK: begin
        if (seek_hit) state_d = SEQ_TGL;
      end
      SEQ_TGL: begin
        state_d = SEQ_DONE;
      end
      SEQ_SCAN: begin
        if (scan_found || scan_last) state_d = SEQ_DONE;
      end
      SEQ_DONE: begin
        if (rsp_free) state_d = SEQ_IDLE;
      end
      default: begin
        state_d = SEQ_IDLE;
      end
    endcase
  end

  // Datapath and memory control per state
  always_comb begin
    w_d         = w_q;
    base_d      = base_q;
    res_d       = res_q;
    req_ready_o = 1'b0;
    ram_we_o    = 1'b0;
    ram_wdata_o = '0;
    unique case (state_q)
      SEQ_CLEAR: begin
        ram_we_o = 1'b1;
        w_d      = (w_q == LastWord) ? '0 : w_q + ADDR_W'(1);
      end
      SEQ_IDLE: begin
        req_ready_o = 1'b1;
        w_d         = '0;
        base_d      = '0;
        if (req_i.mode == MODE_TOGGLE) begin
          res_d = '{status: ST_RANGE, position: '0};
        end else begin
          res_d = '{status: ST_NONE_FREE, position: '0};
        end
      end
      SEQ_SEEK: begin
        if (!seek_hit) begin
          w_d    = w_q + ADDR_W'(1);
          base_d = base_next;
        end
      end
      SEQ_TGL: begin
        ram_we_o    = 1'b1;
        ram_wdata_o = ram_rdata_i ^ tgl_mask;
        res_d       = '{status: ST_OK, position: idx_q};
      end
      SEQ_SCAN: begin
        if (scan_found) begin
          res_d       = '{status: ST_OK, position: scan_pos[POS_W-1:0]};
          ram_we_o    = (mode_q == MODE_ALLOC);
          ram_wdata_o = ram_rdata_i | scan_onehot;
        end else if (scan_last) begin
          res_d = '{status: ST_NONE_FREE, position: '0};
        end else begin
          w_d    = w_q + ADDR_W'(1);
          base_d = base_next;
        end
      end
      SEQ_DONE: begin
        w_d = w_q;
      end
      default: begin
        w_d = w_q;
      end
    endcase
  end

  // Reads address the next word, so the registered read data belongs to the word in use
  assign ram_raddr_o = w_d;
  assign ram_waddr_o = w_q;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SEQ_CLEAR;
      w_q         <= '0;
      base_q      <= '0;
      limit_q     <= BLOCK_LIMIT_RST;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      w_q     <= w_d;
      base_q  <= base_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (state_q == SEQ_DONE && rsp_free) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (req_xfer) begin
      mode_q <= req_i.mode;
      idx_q  <= req_i.bit_index;
    end
    if (state_q == SEQ_DONE && rsp_free) begin
      rsp_q <= res_q;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

[sv/bffa_checker.sv]
`timescale 1ns / 1ps
`include "bitmap_first_free_allocator_defines.svh"

module bffa_checker import bffa_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       req_valid_i,
  input logic       req_ready_o,
  input alloc_req_t req_i,
  input logic       rsp_valid_o,
  input logic       rsp_ready_i,
  input alloc_rsp_t rsp_o
);

  logic       in_xfer;
  logic       out_xfer;
  logic [1:0] open_q;

  assign in_xfer  = req_valid_i && req_ready_o;
  assign out_xfer = rsp_valid_o && rsp_ready_i;

  // Track requests taken but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else begin
      open_q <= open_q + 2'(in_xfer) - 2'(out_xfer);
    end
  end

  `BFFA_ASSERT(a_fail_pos_zero, rsp_valid_o && rsp_o.status != ST_OK |-> rsp_o.position == '0, "failed result carries a nonzero position")
  `BFFA_ASSERT(a_rsp_hold, rsp_valid_o && !rsp_ready_i |=> rsp_valid_o && $stable(rsp_o), "stalled result changed")
  `BFFA_ASSERT(a_rsp_has_req, rsp_valid_o |-> open_q != 2'd0, "result shown without an open request")
  `BFFA_ASSERT(a_open_bound, open_q <= 2'd2, "more than two requests open")
  `BFFA_ASSERT_RST(a_rst_quiet, !rst_ni |-> !rsp_valid_o, "result valid during reset")

endmodule

bind bitmap_first_free_allocator bffa_checker u_bffa_checker (.*);

[verif/tb_bitmap_first_free_allocator.sv]
`timescale 1ns / 1ps

module tb_bitmap_first_free_allocator;
  import bffa_pkg::*;

  localparam int unsigned MAP_SIZE     = 16384;
  localparam int unsigned WATCHDOG_MAX = 4000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned TAIL_CYCLES  = 600;
  localparam int unsigned PHASES       = 12;
  localparam int unsigned PHASE_ITEMS  = 52;
  localparam int unsigned REPORT_MAX   = 10;

  // Unused mode code; the block treats it as a plain search
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  // Limits per random phase, extremes included
  localparam logic [LIMIT_W-1:0] PHASE_LIMITS [PHASES] = '{
    15'd16384, 15'd40, 15'd1, 15'd100, 15'd32767, 15'd0,
    15'd700, 15'd16384, 15'd9, 15'd5000, 15'd64, 15'd33
  };

  typedef struct {
    bit                 set_limit;
    logic [LIMIT_W-1:0] limit;
    logic [MODE_W-1:0]  mode;
    logic [POS_W-1:0]   index;
    bit                 typed;
    logic [STAT_W-1:0]  want_status;
    logic [POS_W-1:0]   want_position;
  } dir_row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       req_valid_i = 1'b0;
  logic       req_ready_o;
  alloc_req_t req_i       = '0;
  logic       rsp_valid_o;
  logic       rsp_ready_i = 1'b0;
  alloc_rsp_t rsp_o;
  logic       cfg_we_i    = 1'b0;
  logic [LIMIT_W-1:0] cfg_wdata_i = '0;

  // Predictor state: usage bit per block and the current limit
  bit                 block_used [MAP_SIZE];
  logic [LIMIT_W-1:0] limit_q = BLOCK_LIMIT_RST;

  alloc_rsp_t alloc_results_due [$];
  dir_row_t   dir_rows [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_ask      = 0;
  int unsigned hold_seen     = 0;
  int unsigned hold_left     = 0;
  int unsigned idle_cycles   = 0;
  int unsigned n_err         = 0;
  alloc_rsp_t  head_rsp;

  bitmap_first_free_allocator u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_ready_i (rsp_ready_i),
    .rsp_o       (rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Compute the result of one request and update the usage map
  function automatic alloc_rsp_t apply_request(input alloc_req_t r);
    int unsigned eff;
    int unsigned p;
    bit          found;
    alloc_rsp_t  o;
    eff = (limit_q > MAP_SIZE) ? MAP_SIZE : limit_q;
    o.status   = ST_OK;
    o.position = '0;
    if (r.mode == MODE_TOGGLE) begin
      if (r.bit_index < eff) begin
        block_used[r.bit_index] = ~block_used[r.bit_index];
        o.position = r.bit_index;
      end else begin
        o.status = ST_RANGE;
      end
    end else begin
      found = 1'b0;
      for (p = 0; p < eff && !found; p++) begin
        if (!block_used[p]) begin
          found = 1'b1;
          o.position = p[POS_W-1:0];
          if (r.mode == MODE_ALLOC) block_used[p] = 1'b1;
        end
      end
      if (!found) o.status = ST_NONE_FREE;
    end
    return o;
  endfunction

  // Offer one request, hold it until the transfer, then queue its result
  task automatic push_req(input alloc_req_t r, input bit typed, input alloc_rsp_t typed_rsp);
    alloc_rsp_t got;
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_i       <= r;
    @(posedge clk_i);
    while (!req_ready_o) @(posedge clk_i);
    got = apply_request(r);
    alloc_results_due.push_back(typed ? typed_rsp : got);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    while (alloc_results_due.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    limit_q     = v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic add_row(input bit set_lim, input logic [LIMIT_W-1:0] lim,
                         input logic [MODE_W-1:0] mode, input logic [POS_W-1:0] idx,
                         input bit typed, input logic [STAT_W-1:0] st,
                         input logic [POS_W-1:0] pos);
    dir_row_t row;
    row.set_limit     = set_lim;
    row.limit         = lim;
    row.mode          = mode;
    row.index         = idx;
    row.typed         = typed;
    row.want_status   = st;
    row.want_position = pos;
    dir_rows.push_back(row);
  endtask

  // Drive the receiver ready; a requested hold-off keeps it low for a while
  always @(negedge clk_i) begin
    if (hold_ask != hold_seen) begin
      hold_seen   <= hold_ask;
      hold_left   <= HOLD_CYCLES;
      rsp_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      rsp_ready_i <= 1'b0;
    end else begin
      rsp_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Check each result transfer against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && rsp_valid_o && rsp_ready_i) begin
      if (alloc_results_due.size() == 0) begin
        n_err++;
        if (n_err <= REPORT_MAX)
          $display("unexpected result: status %0d position %0d", rsp_o.status, rsp_o.position);
      end else begin
        head_rsp = alloc_results_due.pop_front();
        if (rsp_o.status !== head_rsp.status || rsp_o.position !== head_rsp.position) begin
          n_err++;
          if (n_err <= REPORT_MAX)
            $display("result mismatch: status exp %0d got %0d, position exp %0d got %0d",
                     head_rsp.status, rsp_o.status, head_rsp.position, rsp_o.position);
        end
      end
    end
  end

  // Abort when no transfer happens for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (req_valid_i && req_ready_o) || (rsp_valid_o && rsp_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_MAX) begin
      $display("tb_bitmap_first_free_allocator: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    alloc_req_t  rq;
    alloc_rsp_t  want;
    int unsigned eff;
    int unsigned pick;
    int unsigned ph;
    int unsigned i;

    // Assert reset as an edge so the block resets at once
    rst_ni <= 1'b0;

    // Directed rows: basic search, toggles at the top index, unused mode,
    // full map under tiny limits, zero limit, limit above the map
    add_row(0, '0, MODE_FIND, 14'd0, 1, ST_OK, 14'd0);
    add_row(0, '0, MODE_ALLOC, 14'd0, 1, ST_OK, 14'd0);
    add_row(0, '0, MODE_ALLOC, 14'd16383, 0, ST_OK, 14'd0);
    add_row(0, '0, MODE_TOGGLE, 14'd16383, 1, ST_OK, 14'd16383);
    add_row(0, '0, MODE_SPARE, 14'd16383, 0, ST_OK, 14'd0);
    add_row(0, '0, MODE_TOGGLE, 14'd16383, 0, ST_OK, 14'd0);
    add_row(0, '0, MODE_TOGGLE, 14'd0, 0, ST_OK, 14'd0);
    add_row(0, '0, MODE_FIND, 14'd0, 0, ST_OK, 14'd0);
    add_row(1, 15'd1, MODE_ALLOC, 14'd0, 0, ST_OK, 14'd0);
    add_row(0, '0, MODE_ALLOC, 14'd0, 1, ST_NONE_FREE, 14'd0);
    add_row(0, '0, MODE_TOGGLE, 14'd1, 1, ST_RANGE, 14'd0);
    add_row(0, '0, MODE_FIND, 14'd16383, 1, ST_NONE_FREE, 14'd0);
    add_row(1, 15'd0, MODE_FIND, 14'd0, 1, ST_NONE_FREE, 14'd0);
    add_row(0, '0, MODE_TOGGLE, 14'd0, 1, ST_RANGE, 14'd0);
    add_row(0, '0, MODE_ALLOC, 14'd0, 1, ST_NONE_FREE, 14'd0);
    add_row(0, '0, MODE_SPARE, 14'd0, 1, ST_NONE_FREE, 14'd0);
    add_row(1, 15'd32767, MODE_TOGGLE, 14'd16383, 0, ST_OK, 14'd0);
    add_row(0, '0, MODE_ALLOC, 14'd0, 0, ST_OK, 14'd0);
    add_row(0, '0, MODE_TOGGLE, 14'd16383, 0, ST_OK, 14'd0);
    add_row(1, 15'd3, MODE_FIND, 14'd0, 0, ST_OK, 14'd0);
    add_row(0, '0, MODE_TOGGLE, 14'd1, 0, ST_OK, 14'd0);
    add_row(0, '0, MODE_ALLOC, 14'd0, 0, ST_OK, 14'd0);
    add_row(0, '0, MODE_TOGGLE, 14'd3, 1, ST_RANGE, 14'd0);
    add_row(1, 15'd16384, MODE_TOGGLE, 14'h1FFF, 0, ST_OK, 14'd0);
    add_row(0, '0, MODE_TOGGLE, 14'h2AAA, 0, ST_OK, 14'd0);

    // Hold reset, then program the limit
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    write_limit(BLOCK_LIMIT_RST);

    // Walk the directed table
    send_idle_pct = 13;
    recv_idle_pct = 46;
    foreach (dir_rows[k]) begin
      if (dir_rows[k].set_limit) begin
        req_valid_i <= 1'b0;
        @(negedge clk_i);
        wait_drained();
        write_limit(dir_rows[k].limit);
      end
      rq.mode        = dir_rows[k].mode;
      rq.bit_index   = dir_rows[k].index;
      want.status    = dir_rows[k].want_status;
      want.position  = dir_rows[k].want_position;
      push_req(rq, dir_rows[k].typed, want);
    end

    // Random phases, each under its own limit and idle pattern
    for (ph = 0; ph < PHASES; ph++) begin
      unique case (ph / 4)
        0: begin
          send_idle_pct = 13;
          recv_idle_pct = 46;
        end
        1: begin
          send_idle_pct = 46;
          recv_idle_pct = 13;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      req_valid_i <= 1'b0;
      @(negedge clk_i);
      wait_drained();
      write_limit(PHASE_LIMITS[ph]);
      // Stall the result side for a long stretch while requests keep coming
      if (ph == 2 || ph == 9) hold_ask <= hold_ask + 1;
      eff = (limit_q > MAP_SIZE) ? MAP_SIZE : limit_q;
      for (i = 0; i < PHASE_ITEMS; i++) begin
        pick = $urandom_range(99);
        rq.bit_index = POS_W'($urandom_range(MAP_SIZE - 1));
        if (pick < 45) begin
          rq.mode = MODE_ALLOC;
        end else if (pick < 60) begin
          rq.mode = MODE_FIND;
        end else if (pick < 65) begin
          rq.mode = MODE_SPARE;
        end else begin
          rq.mode = MODE_TOGGLE;
          if (eff != 0 && $urandom_range(9) < 7) begin
            rq.bit_index = POS_W'($urandom_range(eff - 1));
          end
        end
        push_req(rq, 1'b0, '0);
      end
    end

    // Drain, then watch for stray results
    req_valid_i <= 1'b0;
    @(negedge clk_i);
    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (n_err == 0 && alloc_results_due.size() == 0) begin
      $display("tb_bitmap_first_free_allocator: clean");
    end else begin
      $display("tb_bitmap_first_free_allocator: errors");
    end
    $finish;
  end

endmodule
